FILE: design/psxa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psxa_pkg
// Shared types, constants and coefficient tables of the ADPCM block decoder.
// ----------------------------------------------------------------------------
package psxa_pkg;

    localparam int MAX_CHANNELS_DEF = 2;

    localparam int HIST_W  = 32;
    localparam int COEF_W  = 8;
    localparam int PROD_W  = HIST_W + COEF_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int PRED_SH = 6;
    localparam int PRED_W  = ACC_W - PRED_SH;
    localparam int SCALE_W = 17;
    localparam int SUM_W   = PRED_W + 1;

    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_FLAGS  = 4'd1;
    localparam logic [3:0] POS_DATA0  = 4'd2;

    localparam logic [3:0] PRED_MAX      = 4'd4;
    localparam logic [3:0] SHIFT_MAX     = 4'd12;
    localparam logic [3:0] SHIFT_DEFAULT = 4'd9;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       channel;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_channel;
        logic [4:0]         sample_pos;
        logic               last_of_run;
    } t_out_word;

    typedef struct packed {
        logic en;
        logic clear;
    } t_mac_ctrl;

    function automatic logic signed [COEF_W-1:0] coef_a(input logic [2:0] p);
        logic signed [COEF_W-1:0] c;
        case (p)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_b(input logic [2:0] p);
        logic signed [COEF_W-1:0] c;
        case (p)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: design/psxa_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psxa_mac
// Shared 32x8 signed multiply-accumulate unit for the prediction term.
// ----------------------------------------------------------------------------
module psxa_mac (
    input  wire logic                                  i_clk,
    input  wire psxa_pkg::t_mac_ctrl                   i_ctrl,
    input  wire logic signed [psxa_pkg::HIST_W-1:0]    i_a,
    input  wire logic signed [psxa_pkg::COEF_W-1:0]    i_c,
    output logic signed [psxa_pkg::ACC_W-1:0]          o_acc
);

    logic signed [psxa_pkg::PROD_W-1:0] w_prod;
    logic signed [psxa_pkg::ACC_W-1:0]  w_prod_ext;
    logic signed [psxa_pkg::ACC_W-1:0]  r_acc;
    logic signed [psxa_pkg::ACC_W-1:0]  n_acc;

    assign w_prod     = i_a * i_c;
    assign w_prod_ext = {w_prod[psxa_pkg::PROD_W-1], w_prod};

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.en) begin
            if (i_ctrl.clear) begin
                n_acc = w_prod_ext;
            end else begin
                n_acc = r_acc + w_prod_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

FILE: design/psxa_hist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psxa_hist
// Per-channel two-deep sample history with one read and one write port.
// ----------------------------------------------------------------------------
module psxa_hist #(
    parameter int MAX_CHANNELS = psxa_pkg::MAX_CHANNELS_DEF,
    parameter int CH_W         = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [CH_W-1:0]                     i_ch,
    input  wire logic                                i_wr_en,
    input  wire logic signed [psxa_pkg::HIST_W-1:0]  i_wr_value,
    output logic signed [psxa_pkg::HIST_W-1:0]       o_h1,
    output logic signed [psxa_pkg::HIST_W-1:0]       o_h2
);

    logic signed [psxa_pkg::HIST_W-1:0] r_h1 [MAX_CHANNELS];
    logic signed [psxa_pkg::HIST_W-1:0] r_h2 [MAX_CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_h1[i] <= '0;
                r_h2[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_h2[i_ch] <= r_h1[i_ch];
            r_h1[i_ch] <= i_wr_value;
        end
    end

    assign o_h1 = r_h1[i_ch];
    assign o_h2 = r_h2[i_ch];

endmodule
`default_nettype wire

FILE: design/psx_adpcm_block_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psx_adpcm_block_decoder_unit
// 4-bit ADPCM block decoder: one byte per input word, two samples per data
// byte, prediction through a shared multiply-accumulate unit.
//
// channel   direction  handshake              word
// in        input      i_in_valid/o_in_stall  t_in_word (byte_value, channel)
// out       output     o_out_valid/i_out_stall t_out_word (sample, channel, ...)
//
// header and flag bytes are taken in the idle state; a data byte is accepted,
// then each of its samples takes two multiply-accumulate passes and one
// sum/saturate step, run in turn on the single 32x8 multiplier.
// reset clears history, block position and latched header fields.
// a stalled output holds the sequencer in its sum step; no input is taken
// until both samples of a data byte have been handed to the output register.
// ----------------------------------------------------------------------------
module psx_adpcm_block_decoder_unit #(
    parameter int MAX_CHANNELS = psxa_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire psxa_pkg::t_in_word  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output psxa_pkg::t_out_word      o_out_data
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL1 = 4'b0010,
        ST_MUL2 = 4'b0100,
        ST_SUM  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [3:0]          r_pos;
    logic [2:0]          r_pred;
    logic [3:0]          r_shift;
    logic                r_cur_channel;
    logic [7:0]          r_byte;
    logic [4:0]          r_base;
    logic                r_k;
    logic                r_out_valid;
    psxa_pkg::t_out_word r_out;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_emit;
    logic [CH_W-1:0]     w_ch_idx;
    logic [3:0]          w_nib;
    logic [3:0]          w_hdr_pred;
    logic [3:0]          w_hdr_shift;
    logic [3:0]          w_pos_m2;

    psxa_pkg::t_mac_ctrl                       w_mac_ctrl;
    logic signed [psxa_pkg::HIST_W-1:0]        w_h1, w_h2, w_mac_a;
    logic signed [psxa_pkg::COEF_W-1:0]        w_mac_c;
    logic signed [psxa_pkg::ACC_W-1:0]         w_acc, w_acc_sh;
    logic signed [psxa_pkg::PRED_W-1:0]        w_pred;
    logic signed [psxa_pkg::SCALE_W-1:0]       w_scale_in, w_scaled;
    logic signed [psxa_pkg::SUM_W-1:0]         w_val;
    logic signed [psxa_pkg::HIST_W-1:0]        w_sat32;
    logic signed [15:0]                        w_sat16;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (r_state == ST_SUM) && w_out_free;
    assign w_ch_idx   = CH_W'(r_cur_channel);

    assign w_hdr_pred  = i_in_data.byte_value[7:4];
    assign w_hdr_shift = i_in_data.byte_value[3:0];
    assign w_pos_m2    = r_pos - psxa_pkg::POS_DATA0;

    // shared multiplier operands
    assign w_mac_ctrl.en    = (r_state == ST_MUL1) || (r_state == ST_MUL2);
    assign w_mac_ctrl.clear = (r_state == ST_MUL1);
    assign w_mac_a = (r_state == ST_MUL1) ? w_h1 : w_h2;
    assign w_mac_c = (r_state == ST_MUL1) ? psxa_pkg::coef_a(r_pred)
                                          : psxa_pkg::coef_b(r_pred);

    psxa_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_mac_ctrl),
        .i_a    (w_mac_a),
        .i_c    (w_mac_c),
        .o_acc  (w_acc)
    );

    psxa_hist #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CH_W         (CH_W)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch       (w_ch_idx),
        .i_wr_en    (w_emit),
        .i_wr_value (w_sat32),
        .o_h1       (w_h1),
        .o_h2       (w_h2)
    );

    // sample sum and saturation
    assign w_nib      = r_k ? r_byte[7:4] : r_byte[3:0];
    assign w_scale_in = {w_nib[3], w_nib, 12'd0};
    assign w_scaled   = w_scale_in >>> r_shift;
    assign w_acc_sh   = w_acc >>> psxa_pkg::PRED_SH;
    assign w_pred     = w_acc_sh[psxa_pkg::PRED_W-1:0];
    assign w_val      = {w_pred[psxa_pkg::PRED_W-1], w_pred}
                      + {{(psxa_pkg::SUM_W-psxa_pkg::SCALE_W){w_scaled[psxa_pkg::SCALE_W-1]}},
                         w_scaled};

    always_comb begin
        if (w_val > $signed({{(psxa_pkg::SUM_W-31){1'b0}}, {31{1'b1}}})) begin
            w_sat32 = {1'b0, {31{1'b1}}};
        end else if (w_val < $signed({{(psxa_pkg::SUM_W-31){1'b1}}, {31{1'b0}}})) begin
            w_sat32 = {1'b1, {31{1'b0}}};
        end else begin
            w_sat32 = w_val[psxa_pkg::HIST_W-1:0];
        end
        if (w_sat32 > 32'sd32767) begin
            w_sat16 = 16'sh7fff;
        end else if (w_sat32 < -32'sd32768) begin
            w_sat16 = -16'sh8000;
        end else begin
            w_sat16 = w_sat32[15:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (r_pos != psxa_pkg::POS_HEADER)
                             && (r_pos != psxa_pkg::POS_FLAGS)) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_SUM;
            ST_SUM: begin
                if (w_out_free) begin
                    n_state = r_k ? ST_IDLE : ST_MUL1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pos         <= '0;
            r_pred        <= '0;
            r_shift       <= '0;
            r_cur_channel <= 1'b0;
            r_k           <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_pos <= r_pos + 4'd1;
                r_k   <= 1'b0;
                if (r_pos == psxa_pkg::POS_HEADER) begin
                    r_pred  <= (w_hdr_pred > psxa_pkg::PRED_MAX) ? 3'd0 : w_hdr_pred[2:0];
                    r_shift <= (w_hdr_shift > psxa_pkg::SHIFT_MAX) ? psxa_pkg::SHIFT_DEFAULT
                                                                   : w_hdr_shift;
                    r_cur_channel <= (32'(i_in_data.channel) < MAX_CHANNELS)
                                   ? i_in_data.channel : 1'b0;
                end
            end else if (w_emit) begin
                r_k <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byte <= i_in_data.byte_value;
            r_base <= {w_pos_m2, 1'b0};
        end
        if (w_emit) begin
            r_out.sample         <= w_sat16;
            r_out.sample_channel <= r_cur_channel;
            r_out.sample_pos     <= r_base | {4'd0, r_k};
            r_out.last_of_run    <= r_k;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_out_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_SUM))
        else $error("output word raised outside the sum step");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.sample_pos <= 5'd27))
        else $error("sample index beyond block length");

    a_last_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_of_run == o_out_data.sample_pos[0]))
        else $error("last_of_run out of step with sample index");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADPCM block decoder. Feeds 16-byte blocks one
// byte per word with random gaps and output stalls. A local decoder computes
// the two samples of each data byte from per-channel history, and every
// output word is checked field by field against the oldest pending sample.
// ----------------------------------------------------------------------------
module tb_top;

    import psxa_pkg::*;

    localparam int     CLK_PERIOD     = 10;
    localparam int     RESET_CYCLES   = 10;
    localparam int     TIMEOUT_CYCLES = 600_000;
    localparam int     DRAIN_CYCLES   = 20;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     MAX_REPORTS    = 10;
    localparam int     RANDOM_BLOCKS  = 75;
    localparam longint NIBBLE_SCALE   = 4096;
    localparam longint HIST_MAX       = 64'sd2147483647;
    localparam longint HIST_MIN       = -64'sd2147483648;
    localparam longint SAMPLE_MAX     = 64'sd32767;
    localparam longint SAMPLE_MIN     = -64'sd32768;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_data;

    // local decoder state
    logic signed [31:0] ch_hist1 [2];
    logic signed [31:0] ch_hist2 [2];
    logic [3:0]         blk_pos;
    logic [2:0]         blk_pred;
    logic [3:0]         blk_shift;
    logic               blk_ch;

    t_out_word pending_samples [$];
    int        mismatch_count = 0;

    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;
    bit hold_request = 1'b0;
    int hold_count = 0;
    int out_burst_left = 0;

    psx_adpcm_block_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic signed [15:0] decode_nibble(input logic ch,
                                                         input logic [3:0] nib);
        longint step;
        longint tap_a;
        longint tap_b;
        longint pred;
        longint acc;
        step = nib[3] ? longint'(nib) - 16 : longint'(nib);
        case (blk_pred)
            3'd1:    begin tap_a = 60;  tap_b = 0;   end
            3'd2:    begin tap_a = 115; tap_b = -52; end
            3'd3:    begin tap_a = 98;  tap_b = -55; end
            3'd4:    begin tap_a = 122; tap_b = -60; end
            default: begin tap_a = 0;   tap_b = 0;   end
        endcase
        pred = (longint'(ch_hist1[ch]) * tap_a + longint'(ch_hist2[ch]) * tap_b) >>> PRED_SH;
        acc  = ((step * NIBBLE_SCALE) >>> blk_shift) + pred;
        if (acc > HIST_MAX) acc = HIST_MAX;
        if (acc < HIST_MIN) acc = HIST_MIN;
        ch_hist2[ch] = ch_hist1[ch];
        ch_hist1[ch] = acc[31:0];
        if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
        if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
        return acc[15:0];
    endfunction

    function automatic void predict_samples(input logic [7:0] b, input logic ch);
        t_out_word w;
        logic [3:0] pos;
        pos = blk_pos;
        blk_pos = blk_pos + 4'd1;
        if (pos == POS_HEADER) begin
            blk_pred  = (b[7:4] > PRED_MAX) ? 3'd0 : b[6:4];
            blk_shift = (b[3:0] > SHIFT_MAX) ? SHIFT_DEFAULT : b[3:0];
            blk_ch    = ch;
        end else if (pos != POS_FLAGS) begin
            for (int k = 0; k < 2; k++) begin
                w.sample         = decode_nibble(blk_ch, (k == 0) ? b[3:0] : b[7:4]);
                w.sample_channel = blk_ch;
                w.sample_pos     = {4'(pos - POS_DATA0), k[0]};
                w.last_of_run    = k[0];
                pending_samples.push_back(w);
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic ch);
        t_in_word w;
        w.byte_value = b;
        w.channel    = ch;
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_samples(b, ch);
    endtask

    function automatic logic [3:0] pick_nibble();
        case ($urandom_range(0, 5))
            0:       return 4'h7;
            1:       return 4'h8;
            default: return 4'($urandom);
        endcase
    endfunction

    // pads to a block boundary first, since any 16 bytes form a block
    task automatic send_random_block();
        logic [3:0] pred_nib;
        while (blk_pos != POS_HEADER) send_byte(8'($urandom), 1'($urandom));
        pred_nib = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 4))
                                               : 4'($urandom_range(5, 15));
        send_byte({pred_nib, 4'($urandom)}, 1'($urandom));
        send_byte(8'($urandom), 1'($urandom));
        repeat (14) send_byte({pick_nibble(), pick_nibble()}, 1'($urandom));
    endtask

    task automatic test_header_clamps();
        localparam logic [8*14-1:0] PATTERN = 112'h08_80_77_88_F0_0F_7F_F7_12_34_AB_CD_69_96;
        send_byte(8'hFD, 1'b1);
        send_byte(8'h00, 1'b0);
        for (int i = 0; i < 14; i++)
            send_byte(PATTERN[8*(13-i) +: 8], 1'(i));
    endtask

    task automatic test_sample_saturation();
        send_byte(8'h40, 1'b0);
        send_byte(8'hFF, 1'b1);
        repeat (3) send_byte(8'h77, 1'b1);
        repeat (4) send_byte(8'h88, 1'b0);
    endtask

    task automatic test_random_blocks();
        repeat (RANDOM_BLOCKS) begin
            in_idle_on  = ($urandom_range(0, 4) != 0);
            out_idle_on = ($urandom_range(0, 4) != 0);
            send_random_block();
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    task automatic test_unframed_bytes();
        repeat ($urandom_range(20, 60)) send_byte(8'($urandom), 1'($urandom));
    endtask

    task automatic test_output_backpressure();
        hold_request <= 1'b1;
        repeat (3) send_random_block();
    endtask

    task automatic test_streaming_no_idle();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        repeat (5) send_random_block();
    endtask

    task automatic note_mismatch(input string why, input t_out_word want,
                                 input t_out_word got);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t %s: expected sample %0d ch %0d idx %0d last %0d,",
                     $realtime, why, want.sample, want.sample_channel, want.sample_pos,
                     want.last_of_run,
                     " got sample %0d ch %0d idx %0d last %0d",
                     got.sample, got.sample_channel, got.sample_pos, got.last_of_run);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_out
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                note_mismatch("unexpected word", '0, o_out_data);
            end else begin
                want = pending_samples.pop_front();
                if (o_out_data.sample !== want.sample ||
                    o_out_data.sample_channel !== want.sample_channel ||
                    o_out_data.sample_pos !== want.sample_pos ||
                    o_out_data.last_of_run !== want.last_of_run)
                    note_mismatch("sample mismatch", want, o_out_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_request) begin
            i_out_stall <= 1'b1;
            hold_count = hold_count + 1;
            if (hold_count >= HOLD_CYCLES) begin
                hold_request <= 1'b0;
                hold_count = 0;
            end
        end else if (out_burst_left > 0) begin
            i_out_stall <= 1'b1;
            out_burst_left = out_burst_left - 1;
        end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            out_burst_left = $urandom_range(0, 12);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        ch_hist1[0] = '0;
        ch_hist1[1] = '0;
        ch_hist2[0] = '0;
        ch_hist2[1] = '0;
        blk_pos     = '0;
        blk_pred    = '0;
        blk_shift   = '0;
        blk_ch      = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_clamps();
        test_sample_saturation();
        test_random_blocks();
        test_unframed_bytes();
        test_output_backpressure();
        test_streaming_no_idle();

        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
design/psxa_pkg.sv
design/psxa_mac.sv
design/psxa_hist.sv
design/psx_adpcm_block_decoder_unit.sv
tb/tb_top.sv
